>>> rtl/core/pstl_pkg.sv
package pstl_pkg;

  localparam int PID_W    = 22;
  localparam int PERIOD_W = 63;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DELETE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_REPLACED = 3'd1,
    ST_DELETED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_DROPPED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_REMOVE,
    OP_INSERT
  } op_t;

  typedef enum logic {
    S_IDLE,
    S_INSERT
  } state_t;

  typedef struct packed {
    logic                used;
    logic [PID_W-1:0]    pid;
    logic [PERIOD_W-1:0] period;
  } slot_t;

  // travels from each cell to its right neighbour
  typedef struct packed {
    logic seen;
    logic ins;
  } link_t;

endpackage

>>> rtl/core/period_sorted_task_list_unit.sv
// delete, not found and dropped items: the result is registered from the remove pass;
//   insert and replace take a remove pass, then an insert shift in the cell row (S_INSERT)
// in_ready is low during the insert pass and while a result waits on out_ready
// reset (rst_n low, synchronous): list empty, count zero, no result pending
module period_sorted_task_list_unit #(
  parameter int CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  logic [pstl_pkg::PID_W-1:0]    in_task_pid,
  input  logic [pstl_pkg::PERIOD_W-1:0] in_period_ns,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pstl_pkg::STATUS_W-1:0] out_status,
  output logic [pstl_pkg::COUNT_W-1:0]  out_entry_count,
  output logic                          out_head_valid,
  output logic [pstl_pkg::PID_W-1:0]    out_head_pid,
  output logic [pstl_pkg::PERIOD_W-1:0] out_head_period
);
  import pstl_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  status_t             status_r, status_nxt;
  logic [PID_W-1:0]    key_pid_r;
  logic [PERIOD_W-1:0] key_period_r;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                out_head_valid_r;
  logic [PID_W-1:0]    out_head_pid_r;
  logic [PERIOD_W-1:0] out_head_period_r;

  op_t                 op;
  logic                accept;
  logic                load_out;
  logic                found;
  logic [PID_W-1:0]    key_pid;
  logic [PERIOD_W-1:0] key_period;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;
  logic [CAPACITY-1:0] used_vec;

  link_t links [CAPACITY+1];
  slot_t slots [CAPACITY+2];
  slot_t head_nxt;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  assign key_pid    = (state_r == S_INSERT) ? key_pid_r : in_task_pid;
  assign key_period = (state_r == S_INSERT) ? key_period_r : in_period_ns;

  assign links[0]          = '{seen: 1'b0, ins: 1'b0};
  assign slots[0]          = '0;
  assign slots[CAPACITY+1] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slot_t cell_nxt;
    pstl_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (op),
      .key_pid    (key_pid),
      .key_period (key_period),
      .link_in    (links[i]),
      .left_slot  (slots[i]),
      .right_slot (slots[i+2]),
      .link_out   (links[i+1]),
      .slot       (slots[i+1]),
      .slot_nxt   (cell_nxt)
    );
    assign used_vec[i] = slots[i+1].used;
  end

  assign head_nxt = g_cell[0].cell_nxt;
  assign found    = links[CAPACITY].seen;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    op         = OP_HOLD;
    load_out   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op      = OP_REMOVE;
          cnt_nxt = cnt_r - CNT_W'(found);
          if (in_func == FUNC_INSERT) begin
            if (found) begin
              status_nxt = ST_REPLACED;
              state_nxt  = S_INSERT;
            end else if (cnt_r == CNT_W'(CAPACITY)) begin
              status_nxt = ST_DROPPED;
              load_out   = 1'b1;
            end else begin
              status_nxt = ST_INSERTED;
              state_nxt  = S_INSERT;
            end
          end else begin
            status_nxt = found ? ST_DELETED : ST_NOTFOUND;
            load_out   = 1'b1;
          end
        end
      end
      S_INSERT: begin
        op        = OP_INSERT;
        cnt_nxt   = cnt_r + CNT_W'(1);
        load_out  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      status_r    <= ST_INSERTED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_pid_r    <= in_task_pid;
      key_period_r <= in_period_ns;
    end
    if (load_out) begin
      out_status_r      <= status_nxt;
      out_count_r       <= cnt_ext[COUNT_W-1:0];
      out_head_valid_r  <= head_nxt.used;
      out_head_pid_r    <= head_nxt.used ? head_nxt.pid : '0;
      out_head_period_r <= head_nxt.used ? head_nxt.period : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;
  assign out_head_valid  = out_head_valid_r;
  assign out_head_pid    = out_head_pid_r;
  assign out_head_period = out_head_period_r;

  // the insert pass only starts with the result register free
  a_insert_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INSERT |-> !out_valid_r)
    else $error("insert pass with result pending");

  a_insert_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INSERT |=> out_valid_r && state_r == S_IDLE)
    else $error("insert pass did not produce a result");

  a_count_matches_used: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_vec) == 32'(cnt_r))
    else $error("held count differs from used cells");

  a_used_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((used_vec >> 1) & ~used_vec) == '0)
    else $error("used cells not packed at the head");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("held count above capacity");

endmodule

>>> rtl/core/pstl_cell.sv
module pstl_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pstl_pkg::op_t           op,
  input  logic [pstl_pkg::PID_W-1:0]    key_pid,
  input  logic [pstl_pkg::PERIOD_W-1:0] key_period,
  input  pstl_pkg::link_t         link_in,
  input  pstl_pkg::slot_t         left_slot,
  input  pstl_pkg::slot_t         right_slot,
  output pstl_pkg::link_t         link_out,
  output pstl_pkg::slot_t         slot,
  output pstl_pkg::slot_t         slot_nxt
);
  import pstl_pkg::*;

  logic                used_r, used_nxt;
  logic [PID_W-1:0]    pid_r, pid_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic                match;
  logic                ins;

  assign match = used_r && (pid_r == key_pid);
  assign ins   = !used_r || (period_r > key_period);

  assign link_out.seen = link_in.seen || match;
  assign link_out.ins  = ins;

  always_comb begin
    used_nxt   = used_r;
    pid_nxt    = pid_r;
    period_nxt = period_r;
    unique case (op)
      OP_REMOVE: begin
        // close the gap: take the right neighbour from the hit onwards
        if (link_out.seen) begin
          used_nxt   = right_slot.used;
          pid_nxt    = right_slot.pid;
          period_nxt = right_slot.period;
        end
      end
      OP_INSERT: begin
        if (ins && link_in.ins) begin
          used_nxt   = left_slot.used;
          pid_nxt    = left_slot.pid;
          period_nxt = left_slot.period;
        end else if (ins) begin
          used_nxt   = 1'b1;
          pid_nxt    = key_pid;
          period_nxt = key_period;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else begin
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pid_r    <= pid_nxt;
    period_r <= period_nxt;
  end

  assign slot     = '{used: used_r, pid: pid_r, period: period_r};
  assign slot_nxt = '{used: used_nxt, pid: pid_nxt, period: period_nxt};

endmodule

>>> dv/tb_top.sv
module tb_top;
  import pstl_pkg::*;

  localparam int CAPACITY = 16;
  localparam int IDLE_PCT = 26;
  localparam int RANDOM_ITEMS = 1750;
  localparam int STALL_LIMIT = 4000;
  localparam int POOL_SIZE = 24;

  typedef struct {
    status_t             status;
    logic [COUNT_W-1:0]  count;
    logic                head_valid;
    logic [PID_W-1:0]    head_pid;
    logic [PERIOD_W-1:0] head_period;
  } list_view_t;

  // ordered task list as the block should hold it, plus the views still awaited
  class order_tracker_t;
    logic [PID_W-1:0]    slot_pid [CAPACITY];
    logic [PERIOD_W-1:0] slot_period [CAPACITY];
    int                  held;
    list_view_t          awaited_views [$];
    int                  mismatches;

    function new();
      held = 0;
      mismatches = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    function void drop_slot(int idx);
      for (int i = idx; i + 1 < held; i++) begin
        slot_pid[i] = slot_pid[i + 1];
        slot_period[i] = slot_period[i + 1];
      end
      held--;
    endfunction

    // goes after every entry of equal or shorter period
    function void put_sorted(logic [PID_W-1:0] pid, logic [PERIOD_W-1:0] period);
      int pos;
      pos = 0;
      while (pos < held && slot_period[pos] <= period) pos++;
      for (int i = held; i > pos; i--) begin
        slot_pid[i] = slot_pid[i - 1];
        slot_period[i] = slot_period[i - 1];
      end
      slot_pid[pos] = pid;
      slot_period[pos] = period;
      held++;
    endfunction

    function void note_op(logic func, logic [PID_W-1:0] pid, logic [PERIOD_W-1:0] period);
      int at;
      list_view_t v;
      at = -1;
      for (int i = 0; i < held; i++)
        if (at < 0 && slot_pid[i] == pid) at = i;
      if (func == FUNC_INSERT) begin
        if (at >= 0) begin
          drop_slot(at);
          put_sorted(pid, period);
          v.status = ST_REPLACED;
        end else if (held >= CAPACITY) begin
          v.status = ST_DROPPED;
        end else begin
          put_sorted(pid, period);
          v.status = ST_INSERTED;
        end
      end else begin
        if (at >= 0) begin
          drop_slot(at);
          v.status = ST_DELETED;
        end else begin
          v.status = ST_NOTFOUND;
        end
      end
      v.count = held[COUNT_W-1:0];
      v.head_valid = (held > 0);
      v.head_pid = (held > 0) ? slot_pid[0] : '0;
      v.head_period = (held > 0) ? slot_period[0] : '0;
      awaited_views.push_back(v);
    endfunction

    task check_result(list_view_t got);
      list_view_t want;
      if (awaited_views.size() == 0) begin
        report($sformatf("result with nothing awaited, status %0d", got.status));
      end else begin
        want = awaited_views.pop_front();
        if (got.status !== want.status)
          report($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.count !== want.count)
          report($sformatf("entry_count %0d, expected %0d", got.count, want.count));
        if (got.head_valid !== want.head_valid)
          report($sformatf("head_valid %0b, expected %0b", got.head_valid, want.head_valid));
        if (got.head_pid !== want.head_pid)
          report($sformatf("head_pid %0h, expected %0h", got.head_pid, want.head_pid));
        if (got.head_period !== want.head_period)
          report($sformatf("head_period %0h, expected %0h", got.head_period,
                           want.head_period));
      end
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_func;
  logic [PID_W-1:0]    in_task_pid;
  logic [PERIOD_W-1:0] in_period_ns;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_entry_count;
  logic                out_head_valid;
  logic [PID_W-1:0]    out_head_pid;
  logic [PERIOD_W-1:0] out_head_period;

  order_tracker_t tracker = new();
  bit idle_en;
  int stall_cycles;
  logic [PID_W-1:0]    pid_pool [POOL_SIZE];
  logic [PERIOD_W-1:0] period_pool [6];

  period_sorted_task_list_unit #(.CAPACITY(CAPACITY)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_task_pid     (in_task_pid),
    .in_period_ns    (in_period_ns),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_head_valid  (out_head_valid),
    .out_head_pid    (out_head_pid),
    .out_head_period (out_head_period)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // called at a rising edge; returns at the edge where the item is taken
  task automatic send_item(logic func, logic [PID_W-1:0] pid, logic [PERIOD_W-1:0] period);
    bit ready_seen;
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_task_pid <= pid;
    in_period_ns <= period;
    do begin
      @(negedge clk);
      ready_seen = in_ready;
      @(posedge clk);
    end while (!ready_seen);
    tracker.note_op(func, pid, period);
  endtask

  function automatic logic [PERIOD_W-1:0] pick_period();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return period_pool[$urandom_range(5)];
    if (roll < 45) return '0;
    if (roll < 50) return '1;
    return PERIOD_W'({$urandom, $urandom} >> $urandom_range(63, 1));
  endfunction

  function automatic void refill_pools();
    for (int i = 0; i < POOL_SIZE; i++) begin
      case ($urandom_range(2))
        0: pid_pool[i] = PID_W'($urandom);
        1: pid_pool[i] = PID_W'($urandom_range(40));
        default: pid_pool[i] = {PID_W{1'b1}} - PID_W'($urandom_range(40));
      endcase
    end
    for (int i = 0; i < 6; i++)
      period_pool[i] = PERIOD_W'({$urandom, $urandom} >> $urandom_range(63, 1));
  endfunction

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= idle_en ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end
  end

  always @(negedge clk) begin
    list_view_t got;
    if (rst_n && out_valid && out_ready) begin
      got.status = status_t'(out_status);
      got.count = out_entry_count;
      got.head_valid = out_head_valid;
      got.head_pid = out_head_pid;
      got.head_period = out_head_period;
      tracker.check_result(got);
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int insert_pct;
    logic [PID_W-1:0] pid;
    idle_en = 1'b1;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_func <= FUNC_INSERT;
    in_task_pid <= '0;
    in_period_ns <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty list, extremes, ties, replacing, filling up, full list
    send_item(FUNC_DELETE, 22'd5, '1);
    send_item(FUNC_INSERT, 22'd0, '1);
    send_item(FUNC_INSERT, '1, '0);
    send_item(FUNC_INSERT, 22'd1, '0);
    send_item(FUNC_INSERT, 22'd0, '0);
    for (int i = 0; i < 13; i++)
      send_item(FUNC_INSERT, 22'h2AAAAA ^ i[PID_W-1:0], PERIOD_W'((i % 3) * 1000));
    send_item(FUNC_INSERT, 22'h155555, 63'd500);
    send_item(FUNC_INSERT, '1, '1);
    send_item(FUNC_DELETE, 22'd1, '0);
    send_item(FUNC_DELETE, 22'd1, '0);

    insert_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        refill_pools();
        case ($urandom_range(2))
          0: insert_pct = 80;
          1: insert_pct = 50;
          default: insert_pct = 25;
        endcase
      end
      idle_en = !(n >= 700 && n < 1000);
      pid = ($urandom_range(99) < 5) ? PID_W'($urandom)
                                     : pid_pool[$urandom_range(POOL_SIZE - 1)];
      if ($urandom_range(99) < 5) pid = PID_W'($urandom);
      send_item(($urandom_range(99) < insert_pct) ? FUNC_INSERT : FUNC_DELETE, pid,
                pick_period());
    end
    in_valid <= 1'b0;

    while (tracker.awaited_views.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
